// File: hdl/atpf_pkg.sv
// Shared types and codes for the box table pair finder.
// Used by atpf_overlap, atpf_cell, aabb_table_pair_finder and tb_top; no dependencies.
`default_nettype none

package atpf_pkg;

    // Corner layout of a packed box: entry a is the lower corner, entry a + AXES the upper
    localparam int AXES = 3;
    localparam int BOX_WORDS = 2 * AXES;

    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_REMOVE = 3'd1;
    localparam logic [2:0] OP_UPDATE = 3'd2;
    localparam logic [2:0] OP_TEST   = 3'd3;
    localparam logic [2:0] OP_FIND   = 3'd4;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_UNUSED = 2'd2;

    localparam int MARGIN_BITS = 16;
    localparam int SLOT_BITS = 5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_EXEC,
        S_SCAN,
        S_END
    } state_t;

    typedef struct packed {
        logic load;
        logic set_use;
        logic clr_use;
    } cell_ctl_t;

endpackage

`default_nettype wire

// File: hdl/atpf_overlap.sv
// Overlap test of two packed boxes; touching boxes count as overlapping.
// Depends on atpf_pkg for the box layout.
`default_nettype none

module atpf_overlap #(
    parameter int COORD_BITS = 24
) (
    input  wire logic [atpf_pkg::BOX_WORDS-1:0][COORD_BITS-1:0] box_a,
    input  wire logic [atpf_pkg::BOX_WORDS-1:0][COORD_BITS-1:0] box_b,
    output logic                                                 overlap
);

    logic [atpf_pkg::AXES-1:0] apart;

    always_comb
    begin
        for (int ax = 0; ax < atpf_pkg::AXES; ax++)
        begin
            apart[ax] = ($signed(box_a[ax + atpf_pkg::AXES]) < $signed(box_b[ax])) ||
                        ($signed(box_a[ax]) > $signed(box_b[ax + atpf_pkg::AXES]));
        end
    end

    assign overlap = ~|apart;

endmodule

`default_nettype wire

// File: hdl/atpf_cell.sv
// One table slot: stored box, in-use bit and one stage of the query token chain.
// Depends on atpf_pkg and atpf_overlap.
`default_nettype none

module atpf_cell #(
    parameter int COORD_BITS = 24,
    parameter int IDX_W      = 5,
    parameter int INDEX      = 0
) (
    input  wire logic                                                 clk,
    input  wire logic                                                 rst_n,
    input  wire atpf_pkg::cell_ctl_t                                  ctl,
    input  wire logic [atpf_pkg::BOX_WORDS-1:0][COORD_BITS-1:0]       wr_box,
    input  wire logic                                                 tok_in_valid,
    input  wire logic [atpf_pkg::BOX_WORDS-1:0][COORD_BITS-1:0]       tok_in_box,
    input  wire logic [IDX_W-1:0]                                     tok_in_slot,
    output logic                                                      tok_out_valid,
    output logic [atpf_pkg::BOX_WORDS-1:0][COORD_BITS-1:0]            tok_out_box,
    output logic [IDX_W-1:0]                                          tok_out_slot,
    output logic                                                      in_use,
    output logic [atpf_pkg::BOX_WORDS-1:0][COORD_BITS-1:0]            box,
    output logic                                                      hit
);

    logic                                                 use_reg;
    logic [atpf_pkg::BOX_WORDS-1:0][COORD_BITS-1:0]       box_reg;
    logic                                                 tok_valid_reg;
    logic [atpf_pkg::BOX_WORDS-1:0][COORD_BITS-1:0]       tok_box_reg;
    logic [IDX_W-1:0]                                     tok_slot_reg;
    logic                                                 ovl;

    atpf_overlap #(
        .COORD_BITS(COORD_BITS)
    ) u_ovl (
        .box_a  (box_reg),
        .box_b  (tok_in_box),
        .overlap(ovl)
    );

    // Report only slots above the query slot
    assign hit = tok_in_valid && use_reg && (tok_in_slot < IDX_W'(INDEX)) && ovl;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use_reg       <= 1'b0;
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            tok_valid_reg <= tok_in_valid;
            if (ctl.set_use)
            begin
                use_reg <= 1'b1;
            end
            else if (ctl.clr_use)
            begin
                use_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tok_box_reg  <= tok_in_box;
        tok_slot_reg <= tok_in_slot;
        if (ctl.load)
        begin
            box_reg <= wr_box;
        end
    end

    assign tok_out_valid = tok_valid_reg;
    assign tok_out_box   = tok_box_reg;
    assign tok_out_slot  = tok_slot_reg;
    assign in_use        = use_reg;
    assign box           = box_reg;

endmodule

`default_nettype wire

// File: hdl/aabb_table_pair_finder.sv
// Box table with free-slot stack, update with margin, overlap test and pair search.
// Depends on atpf_pkg, atpf_overlap and atpf_cell.
//
//  Channel   Signals                                         Handshake
//  command   start, busy, op, slot, other_slot, min_*/max_*   taken when start & !busy
//  result    result_valid, assigned_slot, pair_*, hit,        one-cycle strobe
//            status, last
//  margin    margin_we, margin_data                          written when margin_we
//
// Insert, remove, update, test: busy in fetch and exec; result strobed after exec.
// Find pairs: busy in fetch, exec, scan and end; the query token walks the chain one
// cell per clock, so pairs come out in slot order followed by the end marker.
// Unknown op codes are taken and dropped with no result.
// Reset clears the in-use bits, stack count, high-water mark and sets the margin to 0.5.
// The receiver cannot stall; every result is strobed for exactly one cycle.
`default_nettype none

module aabb_table_pair_finder #(
    parameter int MAX_BOXES  = 32,
    parameter int COORD_BITS = 24,
    parameter int FRAC_BITS  = 8
) (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    start,
    output logic                                         busy,
    input  wire logic [2:0]                              op,
    input  wire logic [atpf_pkg::SLOT_BITS-1:0]          slot,
    input  wire logic [atpf_pkg::SLOT_BITS-1:0]          other_slot,
    input  wire logic signed [COORD_BITS-1:0]            min_x,
    input  wire logic signed [COORD_BITS-1:0]            min_y,
    input  wire logic signed [COORD_BITS-1:0]            min_z,
    input  wire logic signed [COORD_BITS-1:0]            max_x,
    input  wire logic signed [COORD_BITS-1:0]            max_y,
    input  wire logic signed [COORD_BITS-1:0]            max_z,
    input  wire logic                                    margin_we,
    input  wire logic [atpf_pkg::MARGIN_BITS-1:0]        margin_data,
    output logic                                         result_valid,
    output logic [atpf_pkg::SLOT_BITS-1:0]               assigned_slot,
    output logic [atpf_pkg::SLOT_BITS-1:0]               pair_low,
    output logic [atpf_pkg::SLOT_BITS-1:0]               pair_high,
    output logic                                         hit,
    output logic [1:0]                                   status,
    output logic                                         last
);

    localparam int IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CNT_W = $clog2(MAX_BOXES + 1);
    localparam int EXT_W = ((COORD_BITS > atpf_pkg::MARGIN_BITS) ?
                            COORD_BITS : atpf_pkg::MARGIN_BITS) + 2;
    localparam int NW    = atpf_pkg::BOX_WORDS;
    localparam int AX    = atpf_pkg::AXES;
    localparam int SW    = atpf_pkg::SLOT_BITS;

    localparam logic signed [EXT_W-1:0] C_MAX =
        EXT_W'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
    localparam logic signed [EXT_W-1:0] C_MIN = -C_MAX - EXT_W'(1);
    localparam logic [atpf_pkg::MARGIN_BITS-1:0] MARGIN_RST =
        atpf_pkg::MARGIN_BITS'((32'd1 << FRAC_BITS) >> 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_BOXES - 1);
    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_BOXES);

    typedef logic [NW-1:0][COORD_BITS-1:0] box_t;

    // Control state
    atpf_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] free_cnt_reg, free_cnt_next;
    logic [CNT_W-1:0] hw_reg, hw_next;
    logic [IDX_W-1:0] scan_reg, scan_next;
    logic [atpf_pkg::MARGIN_BITS-1:0] margin_reg;
    logic             rv_reg, rv_next;

    // Transaction payload
    logic [2:0]       op_reg;
    logic [SW-1:0]    slot_reg;
    logic [SW-1:0]    other_reg;
    box_t             new_reg;
    box_t             q_reg;
    logic [IDX_W-1:0] tos_reg;

    // Result payload
    logic [SW-1:0] as_reg, as_next;
    logic [SW-1:0] plo_reg, plo_next;
    logic [SW-1:0] phi_reg, phi_next;
    logic          hit_reg, hit_next;
    logic [1:0]    st_reg, st_next;
    logic          last_reg, last_next;

    // Free stack
    logic [IDX_W-1:0] stack_mem [MAX_BOXES];
    logic [IDX_W-1:0] stack_rd_addr;
    logic             push;

    // Cell side
    atpf_pkg::cell_ctl_t       cell_ctl [MAX_BOXES];
    logic                      wr_load, wr_set, wr_clr;
    logic [IDX_W-1:0]          wr_idx;
    box_t                      wr_data;
    box_t                      cell_box [MAX_BOXES];
    logic [MAX_BOXES-1:0]      cell_use;
    logic [MAX_BOXES-1:0]      cell_hit;
    logic                      chain_valid [MAX_BOXES+1];
    box_t                      chain_box [MAX_BOXES+1];
    logic [IDX_W-1:0]          chain_slot [MAX_BOXES+1];

    logic       accept;
    logic       slot_ok, other_ok;
    logic       contained;
    logic       test_ovl;
    box_t       wide_box;
    box_t       new_box;
    logic [IDX_W-1:0] slot_idx, other_idx;

    assign accept    = start && (state_reg == atpf_pkg::S_IDLE);
    assign slot_idx  = IDX_W'(slot_reg);
    assign other_idx = IDX_W'(other_reg);
    assign slot_ok   = (32'(slot_reg) < MAX_BOXES) && cell_use[slot_idx];
    assign other_ok  = (32'(other_reg) < MAX_BOXES) && cell_use[other_idx];
    assign new_box   = {max_z, max_y, max_x, min_z, min_y, min_x};

    // Query token enters the chain at cell 0 on the first scan cycle
    assign chain_valid[0] = (state_reg == atpf_pkg::S_SCAN) && (scan_reg == '0);
    assign chain_box[0]   = q_reg;
    assign chain_slot[0]  = slot_idx;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_BOXES; gi++)
        begin : g_cell
            assign cell_ctl[gi] = '{
                load:    wr_load && (wr_idx == IDX_W'(gi)),
                set_use: wr_set && (wr_idx == IDX_W'(gi)),
                clr_use: wr_clr && (wr_idx == IDX_W'(gi))
            };

            atpf_cell #(
                .COORD_BITS(COORD_BITS),
                .IDX_W     (IDX_W),
                .INDEX     (gi)
            ) u_cell (
                .clk          (clk),
                .rst_n        (rst_n),
                .ctl          (cell_ctl[gi]),
                .wr_box       (wr_data),
                .tok_in_valid (chain_valid[gi]),
                .tok_in_box   (chain_box[gi]),
                .tok_in_slot  (chain_slot[gi]),
                .tok_out_valid(chain_valid[gi+1]),
                .tok_out_box  (chain_box[gi+1]),
                .tok_out_slot (chain_slot[gi+1]),
                .in_use       (cell_use[gi]),
                .box          (cell_box[gi]),
                .hit          (cell_hit[gi])
            );
        end
    endgenerate

    atpf_overlap #(
        .COORD_BITS(COORD_BITS)
    ) u_test_ovl (
        .box_a  (q_reg),
        .box_b  (cell_box[other_idx]),
        .overlap(test_ovl)
    );

    // Containment of the new box by the stored one, and the widened, saturated box
    always_comb
    begin
        logic signed [EXT_W-1:0] m_ext;
        logic signed [EXT_W-1:0] lo_ext;
        logic signed [EXT_W-1:0] hi_ext;
        m_ext     = EXT_W'(margin_reg);
        contained = 1'b1;
        wide_box  = '0;
        for (int ax = 0; ax < AX; ax++)
        begin
            if (($signed(q_reg[ax]) > $signed(new_reg[ax])) ||
                ($signed(q_reg[ax + AX]) < $signed(new_reg[ax + AX])))
            begin
                contained = 1'b0;
            end
            lo_ext = EXT_W'($signed(new_reg[ax])) - m_ext;
            hi_ext = EXT_W'($signed(new_reg[ax + AX])) + m_ext;
            wide_box[ax]      = (lo_ext < C_MIN) ? C_MIN[COORD_BITS-1:0] :
                                lo_ext[COORD_BITS-1:0];
            wide_box[ax + AX] = (hi_ext > C_MAX) ? C_MAX[COORD_BITS-1:0] :
                                hi_ext[COORD_BITS-1:0];
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            atpf_pkg::S_IDLE:
            begin
                if (accept && (op <= atpf_pkg::OP_FIND))
                begin
                    state_next = atpf_pkg::S_FETCH;
                end
            end
            atpf_pkg::S_FETCH:
            begin
                state_next = atpf_pkg::S_EXEC;
            end
            atpf_pkg::S_EXEC:
            begin
                if ((op_reg == atpf_pkg::OP_FIND) && slot_ok)
                begin
                    state_next = atpf_pkg::S_SCAN;
                end
                else
                begin
                    state_next = atpf_pkg::S_IDLE;
                end
            end
            atpf_pkg::S_SCAN:
            begin
                if (scan_reg == LAST_IDX)
                begin
                    state_next = atpf_pkg::S_END;
                end
            end
            atpf_pkg::S_END:
            begin
                state_next = atpf_pkg::S_IDLE;
            end
            default:
            begin
                state_next = atpf_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs, table writes and counters
    always_comb
    begin
        rv_next       = 1'b0;
        as_next       = '0;
        plo_next      = '0;
        phi_next      = '0;
        hit_next      = 1'b0;
        st_next       = atpf_pkg::ST_OK;
        last_next     = 1'b1;
        free_cnt_next = free_cnt_reg;
        hw_next       = hw_reg;
        scan_next     = '0;
        wr_load       = 1'b0;
        wr_set        = 1'b0;
        wr_clr        = 1'b0;
        wr_idx        = slot_idx;
        wr_data       = new_reg;
        push          = 1'b0;
        unique case (state_reg)
            atpf_pkg::S_EXEC:
            begin
                unique case (op_reg)
                    atpf_pkg::OP_INSERT:
                    begin
                        rv_next = 1'b1;
                        if (free_cnt_reg != '0)
                        begin
                            free_cnt_next = free_cnt_reg - 1'b1;
                            wr_idx        = tos_reg;
                            wr_load       = 1'b1;
                            wr_set        = 1'b1;
                        end
                        else if (hw_reg < CNT_MAX)
                        begin
                            hw_next = hw_reg + 1'b1;
                            wr_idx  = IDX_W'(hw_reg);
                            wr_load = 1'b1;
                            wr_set  = 1'b1;
                        end
                        else
                        begin
                            st_next = atpf_pkg::ST_FULL;
                        end
                        if (wr_set)
                        begin
                            as_next = SW'(wr_idx);
                        end
                    end
                    atpf_pkg::OP_REMOVE:
                    begin
                        rv_next = 1'b1;
                        if (!slot_ok)
                        begin
                            st_next = atpf_pkg::ST_UNUSED;
                        end
                        else
                        begin
                            wr_clr = 1'b1;
                            if (free_cnt_reg < CNT_MAX)
                            begin
                                push          = 1'b1;
                                free_cnt_next = free_cnt_reg + 1'b1;
                            end
                        end
                    end
                    atpf_pkg::OP_UPDATE:
                    begin
                        rv_next = 1'b1;
                        wr_data = wide_box;
                        if (!slot_ok)
                        begin
                            st_next = atpf_pkg::ST_UNUSED;
                        end
                        else if (!contained)
                        begin
                            wr_load = 1'b1;
                        end
                    end
                    atpf_pkg::OP_TEST:
                    begin
                        rv_next = 1'b1;
                        if (!slot_ok || !other_ok)
                        begin
                            st_next = atpf_pkg::ST_UNUSED;
                        end
                        else
                        begin
                            plo_next = (slot_reg < other_reg) ? slot_reg : other_reg;
                            phi_next = (slot_reg < other_reg) ? other_reg : slot_reg;
                            hit_next = test_ovl;
                        end
                    end
                    atpf_pkg::OP_FIND:
                    begin
                        // A valid query goes on to the scan with no result here
                        if (!slot_ok)
                        begin
                            rv_next = 1'b1;
                            st_next = atpf_pkg::ST_UNUSED;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            atpf_pkg::S_SCAN:
            begin
                scan_next = scan_reg + 1'b1;
                if (|cell_hit)
                begin
                    rv_next   = 1'b1;
                    plo_next  = slot_reg;
                    phi_next  = SW'(scan_reg);
                    hit_next  = 1'b1;
                    last_next = 1'b0;
                end
            end
            atpf_pkg::S_END:
            begin
                rv_next = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign busy = (state_reg != atpf_pkg::S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= atpf_pkg::S_IDLE;
            free_cnt_reg <= '0;
            hw_reg       <= '0;
            scan_reg     <= '0;
            margin_reg   <= MARGIN_RST;
            rv_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            free_cnt_reg <= free_cnt_next;
            hw_reg       <= hw_next;
            scan_reg     <= scan_next;
            rv_reg       <= rv_next;
            if (margin_we)
            begin
                margin_reg <= margin_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= op;
            slot_reg  <= slot;
            other_reg <= other_slot;
            new_reg   <= new_box;
        end
        if (state_reg == atpf_pkg::S_FETCH)
        begin
            q_reg <= cell_box[slot_idx];
        end
        as_reg   <= as_next;
        plo_reg  <= plo_next;
        phi_reg  <= phi_next;
        hit_reg  <= hit_next;
        st_reg   <= st_next;
        last_reg <= last_next;
    end

    // Top of the free stack is read every cycle; the count changes only in the execute state
    assign stack_rd_addr = (free_cnt_reg == '0) ? '0 : IDX_W'(free_cnt_reg - 1'b1);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            stack_mem[IDX_W'(free_cnt_reg)] <= slot_idx;
        end
        tos_reg <= stack_mem[stack_rd_addr];
    end

    assign result_valid  = rv_reg;
    assign assigned_slot = as_reg;
    assign pair_low      = plo_reg;
    assign pair_high     = phi_reg;
    assign hit           = hit_reg;
    assign status        = st_reg;
    assign last          = last_reg;

`ifndef SYNTHESIS
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last) |-> !busy)
        else $error("final result strobed while still busy");

    a_one_hit: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cell_hit))
        else $error("more than one cell reports a hit");

    a_slot_count: assert property (@(posedge clk) disable iff (!rst_n)
        ($countones(cell_use) + int'(free_cnt_reg)) == int'(hw_reg))
        else $error("slots in use plus free slots differ from high-water mark");

    a_full_hw: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (status == atpf_pkg::ST_FULL)) |-> (hw_reg == CNT_MAX))
        else $error("table full reported below capacity");
`endif

endmodule

`default_nettype wire

// File: test/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for aabb_table_pair_finder: directed corner cases, then random
// insert/remove/update/test/find traffic over several fatten margins, scored per result.
// Depends on atpf_pkg and the aabb_table_pair_finder RTL with its atpf_cell and atpf_overlap.

module tb_top;

    localparam int TABLE_SLOTS = 32;
    localparam int COORD_W = 24;
    localparam int SLOT_W = atpf_pkg::SLOT_BITS;
    localparam int MARGIN_W = atpf_pkg::MARGIN_BITS;
    localparam longint COORD_MAX = (longint'(1) <<< (COORD_W - 1)) - 1;
    localparam longint COORD_MIN = -COORD_MAX - 1;
    localparam logic [MARGIN_W-1:0] MARGIN_AT_RESET = 16'd128;

    // op codes the block drops without a result
    localparam logic [2:0] OP_SPARE_5 = 3'd5;
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    localparam int PHASES = 6;
    localparam int ITEMS_PER_PHASE = 58;
    localparam int DRAIN_CYCLES = TABLE_SLOTS + 8;
    localparam int TAIL_CYCLES = TABLE_SLOTS + 8;
    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_REPORTS = 100;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        logic [2:0]                 op;
        logic [SLOT_W-1:0]          slot;
        logic [SLOT_W-1:0]          other;
        logic [2:0][COORD_W-1:0]    lo;
        logic [2:0][COORD_W-1:0]    hi;
    } command_t;

    typedef struct packed {
        logic [SLOT_W-1:0]      assigned_slot;
        logic [SLOT_W-1:0]      pair_low;
        logic [SLOT_W-1:0]      pair_high;
        logic                   hit;
        logic [1:0]             status;
        logic                   last;
    } result_t;

    class box_table_checker;
        coord_t lower [TABLE_SLOTS][3];
        coord_t upper [TABLE_SLOTS][3];
        bit live [TABLE_SLOTS];
        logic [SLOT_W-1:0] freed [TABLE_SLOTS];
        int free_top;
        int next_fresh;
        logic [MARGIN_W-1:0] margin;
        result_t awaited [$];
        int errors;

        function new();
            foreach (live[i])
                live[i] = 1'b0;
            free_top = 0;
            next_fresh = 0;
            margin = MARGIN_AT_RESET;
            errors = 0;
        endfunction

        function coord_t clamp(longint v);
            coord_t r;
            if (v > COORD_MAX)
                v = COORD_MAX;
            else if (v < COORD_MIN)
                v = COORD_MIN;
            r = coord_t'(v);
            return r;
        endfunction

        // touching boxes count as overlapping
        function bit boxes_overlap(int a, int b);
            int k;
            for (k = 0; k < 3; k++)
                if (upper[a][k] < lower[b][k] || lower[a][k] > upper[b][k])
                    return 1'b0;
            return 1'b1;
        endfunction

        function void await_result(int as, int lo, int hi, bit h, logic [1:0] st, bit lst);
            result_t r;
            r.assigned_slot = SLOT_W'(as);
            r.pair_low = SLOT_W'(lo);
            r.pair_high = SLOT_W'(hi);
            r.hit = h;
            r.status = st;
            r.last = lst;
            awaited.push_back(r);
        endfunction

        function int random_live();
            int picks [$];
            for (int i = 0; i < TABLE_SLOTS; i++)
                if (live[i])
                    picks.push_back(i);
            if (picks.size() == 0)
                return $urandom_range(0, TABLE_SLOTS - 1);
            return picks[$urandom_range(0, picks.size() - 1)];
        endfunction

        function void note_command(command_t c);
            coord_t nlo [3];
            coord_t nhi [3];
            int id, k, j, s, t;
            bit holds;
            s = c.slot;
            t = c.other;
            for (k = 0; k < 3; k++)
            begin
                nlo[k] = c.lo[k];
                nhi[k] = c.hi[k];
            end
            case (c.op)
                atpf_pkg::OP_INSERT:
                begin
                    if (free_top > 0)
                    begin
                        free_top--;
                        id = freed[free_top];
                    end
                    else if (next_fresh < TABLE_SLOTS)
                        id = next_fresh++;
                    else
                    begin
                        await_result(0, 0, 0, 1'b0, atpf_pkg::ST_FULL, 1'b1);
                        return;
                    end
                    for (k = 0; k < 3; k++)
                    begin
                        lower[id][k] = nlo[k];
                        upper[id][k] = nhi[k];
                    end
                    live[id] = 1'b1;
                    await_result(id, 0, 0, 1'b0, atpf_pkg::ST_OK, 1'b1);
                end
                atpf_pkg::OP_REMOVE:
                begin
                    if (!live[s])
                    begin
                        await_result(0, 0, 0, 1'b0, atpf_pkg::ST_UNUSED, 1'b1);
                        return;
                    end
                    live[s] = 1'b0;
                    if (free_top < TABLE_SLOTS)
                        freed[free_top++] = SLOT_W'(s);
                    await_result(0, 0, 0, 1'b0, atpf_pkg::ST_OK, 1'b1);
                end
                atpf_pkg::OP_UPDATE:
                begin
                    if (!live[s])
                    begin
                        await_result(0, 0, 0, 1'b0, atpf_pkg::ST_UNUSED, 1'b1);
                        return;
                    end
                    holds = 1'b1;
                    for (k = 0; k < 3; k++)
                        if (lower[s][k] > nlo[k] || upper[s][k] < nhi[k])
                            holds = 1'b0;
                    // store the new box fattened only when the old one no longer covers it
                    if (!holds)
                        for (k = 0; k < 3; k++)
                        begin
                            lower[s][k] = clamp(longint'(nlo[k]) - longint'(margin));
                            upper[s][k] = clamp(longint'(nhi[k]) + longint'(margin));
                        end
                    await_result(0, 0, 0, 1'b0, atpf_pkg::ST_OK, 1'b1);
                end
                atpf_pkg::OP_TEST:
                begin
                    if (!live[s] || !live[t])
                        await_result(0, 0, 0, 1'b0, atpf_pkg::ST_UNUSED, 1'b1);
                    else
                        await_result(0, (s < t) ? s : t, (s < t) ? t : s,
                                     boxes_overlap(s, t), atpf_pkg::ST_OK, 1'b1);
                end
                atpf_pkg::OP_FIND:
                begin
                    if (!live[s])
                    begin
                        await_result(0, 0, 0, 1'b0, atpf_pkg::ST_UNUSED, 1'b1);
                        return;
                    end
                    for (j = s + 1; j < TABLE_SLOTS; j++)
                        if (live[j] && boxes_overlap(s, j))
                            await_result(0, s, j, 1'b1, atpf_pkg::ST_OK, 1'b0);
                    await_result(0, 0, 0, 1'b0, atpf_pkg::ST_OK, 1'b1);
                end
                default:
                begin
                end
            endcase
        endfunction

        task report(string what);
            if (errors < MAX_REPORTS)
                $display("MISMATCH at %0t: %s", $time, what);
            errors++;
        endtask

        task check_field(string name, logic [7:0] got, logic [7:0] want);
            if (got !== want)
                report($sformatf("%s got %0d, expected %0d", name, got, want));
        endtask

        task check_result(result_t got);
            result_t want;
            if (awaited.size() == 0)
            begin
                report("result strobed with no transaction outstanding");
                return;
            end
            want = awaited.pop_front();
            check_field("assigned_slot", got.assigned_slot, want.assigned_slot);
            check_field("pair_low", got.pair_low, want.pair_low);
            check_field("pair_high", got.pair_high, want.pair_high);
            check_field("hit", got.hit, want.hit);
            check_field("status", got.status, want.status);
            check_field("last", got.last, want.last);
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [2:0] op = atpf_pkg::OP_INSERT;
    logic [SLOT_W-1:0] slot = '0;
    logic [SLOT_W-1:0] other_slot = '0;
    logic signed [COORD_W-1:0] min_x = '0;
    logic signed [COORD_W-1:0] min_y = '0;
    logic signed [COORD_W-1:0] min_z = '0;
    logic signed [COORD_W-1:0] max_x = '0;
    logic signed [COORD_W-1:0] max_y = '0;
    logic signed [COORD_W-1:0] max_z = '0;
    logic margin_we = 1'b0;
    logic [MARGIN_W-1:0] margin_data = '0;
    logic result_valid;
    logic [SLOT_W-1:0] assigned_slot;
    logic [SLOT_W-1:0] pair_low;
    logic [SLOT_W-1:0] pair_high;
    logic hit;
    logic [1:0] status;
    logic last;

    box_table_checker sb = new();

    always #5 clk = ~clk;

    aabb_table_pair_finder #(
        .MAX_BOXES  (TABLE_SLOTS),
        .COORD_BITS (COORD_W),
        .FRAC_BITS  (8)
    ) DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .op             (op),
        .slot           (slot),
        .other_slot     (other_slot),
        .min_x          (min_x),
        .min_y          (min_y),
        .min_z          (min_z),
        .max_x          (max_x),
        .max_y          (max_y),
        .max_z          (max_z),
        .margin_we      (margin_we),
        .margin_data    (margin_data),
        .result_valid   (result_valid),
        .assigned_slot  (assigned_slot),
        .pair_low       (pair_low),
        .pair_high      (pair_high),
        .hit            (hit),
        .status         (status),
        .last           (last)
    );

    // results cannot be held off: score every strobe on the edge that ends it
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            sb.check_result({assigned_slot, pair_low, pair_high, hit, status, last});
    end

    function automatic command_t box_cmd(logic [2:0] o, int s, int t,
                                         longint lx, longint ly, longint lz,
                                         longint hx, longint hy, longint hz);
        command_t c;
        c.op = o;
        c.slot = SLOT_W'(s);
        c.other = SLOT_W'(t);
        c.lo[0] = COORD_W'(lx);
        c.lo[1] = COORD_W'(ly);
        c.lo[2] = COORD_W'(lz);
        c.hi[0] = COORD_W'(hx);
        c.hi[1] = COORD_W'(hy);
        c.hi[2] = COORD_W'(hz);
        return c;
    endfunction

    function automatic int pick_slot();
        if ($urandom_range(0, 99) < 85)
            return sb.random_live();
        return $urandom_range(0, TABLE_SLOTS - 1);
    endfunction

    // mostly small clustered boxes so pairs are common; some raw, extreme and inverted ones
    function automatic command_t random_box();
        command_t c;
        int a, kind, mid, half;
        c = '0;
        kind = $urandom_range(0, 99);
        for (a = 0; a < 3; a++)
        begin
            mid = $urandom_range(0, 8191) - 4096;
            half = $urandom_range(0, 1536);
            if (kind < 78)
            begin
                c.lo[a] = COORD_W'(mid - half);
                c.hi[a] = COORD_W'(mid + half);
            end
            else if (kind < 90)
            begin
                c.lo[a] = COORD_W'($urandom);
                c.hi[a] = COORD_W'($urandom);
            end
            else if (kind < 96)
            begin
                c.lo[a] = COORD_W'(COORD_MIN + half);
                c.hi[a] = COORD_W'(COORD_MAX - half);
            end
            else
            begin
                c.lo[a] = COORD_W'(mid + half);
                c.hi[a] = COORD_W'(mid - half);
            end
        end
        return c;
    endfunction

    // style 0 fills the table, 1 is balanced, 2 drains it
    function automatic command_t random_command(int style);
        command_t c;
        int roll, ins_pct, rem_pct, a, s;
        bit same;
        c = random_box();
        ins_pct = (style == 0) ? 50 : (style == 1) ? 22 : 10;
        rem_pct = (style == 2) ? 38 : (style == 1) ? 16 : 8;
        c.slot = SLOT_W'(pick_slot());
        c.other = ($urandom_range(0, 9) == 0) ? c.slot : SLOT_W'(pick_slot());
        roll = $urandom_range(0, 99);
        if (roll < 3)
        begin
            case ($urandom_range(0, 2))
                0: c.op = OP_SPARE_5;
                1: c.op = OP_SPARE_6;
                default: c.op = OP_SPARE_7;
            endcase
        end
        else if (roll < 3 + ins_pct)
            c.op = atpf_pkg::OP_INSERT;
        else if (roll < 3 + ins_pct + rem_pct)
            c.op = atpf_pkg::OP_REMOVE;
        else
        begin
            case ($urandom_range(0, 2))
                0: c.op = atpf_pkg::OP_UPDATE;
                1: c.op = atpf_pkg::OP_TEST;
                default: c.op = atpf_pkg::OP_FIND;
            endcase
        end
        // move a stored box a little so containment goes both ways
        s = c.slot;
        if (c.op == atpf_pkg::OP_UPDATE && sb.live[s] && $urandom_range(0, 1))
        begin
            same = ($urandom_range(0, 2) == 0);
            for (a = 0; a < 3; a++)
            begin
                c.lo[a] = COORD_W'(int'(sb.lower[s][a]) +
                                   (same ? 0 : int'($urandom_range(0, 400)) - 200));
                c.hi[a] = COORD_W'(int'(sb.upper[s][a]) +
                                   (same ? 0 : int'($urandom_range(0, 400)) - 200));
            end
        end
        return c;
    endfunction

    task automatic send_command(command_t c);
        start <= 1'b1;
        op <= c.op;
        slot <= c.slot;
        other_slot <= c.other;
        min_x <= c.lo[0];
        min_y <= c.lo[1];
        min_z <= c.lo[2];
        max_x <= c.hi[0];
        max_y <= c.hi[1];
        max_z <= c.hi[2];
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_command(c);
    endtask

    task automatic idle_burst();
        start <= 1'b0;
        repeat ($urandom_range(1, 12))
            @(posedge clk);
    endtask

    // write only with nothing outstanding and any dropped op long finished
    task automatic write_margin(logic [MARGIN_W-1:0] value);
        start <= 1'b0;
        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        margin_we <= 1'b1;
        margin_data <= value;
        @(posedge clk);
        margin_we <= 1'b0;
        sb.margin = value;
    endtask

    initial
    begin
        repeat (CYCLE_LIMIT)
            @(posedge clk);
        $display("** aabb_table_pair_finder: FAILED **");
        $finish;
    end

    initial
    begin
        logic [MARGIN_W-1:0] margins [PHASES];
        command_t c;
        int phase, counted, idle_pct;

        margins[0] = 16'd0;
        margins[1] = 16'hFFFF;
        margins[2] = 16'd1;
        margins[3] = MARGIN_W'($urandom);
        margins[4] = MARGIN_AT_RESET;
        margins[5] = MARGIN_W'($urandom);

        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table: every addressed slot is unused
        send_command(box_cmd(atpf_pkg::OP_REMOVE, 0, 0, 0, 0, 0, 0, 0, 0));
        send_command(box_cmd(atpf_pkg::OP_FIND, 0, 0, 0, 0, 0, 0, 0, 0));
        send_command(box_cmd(atpf_pkg::OP_TEST, 0, 1, 0, 0, 0, 0, 0, 0));
        send_command(box_cmd(atpf_pkg::OP_INSERT, 0, 0, -256, -256, -256, 256, 256, 256));
        send_command(box_cmd(atpf_pkg::OP_INSERT, 0, 0, 0, 0, 0, 512, 512, 512));
        // touches slot 0 on x
        send_command(box_cmd(atpf_pkg::OP_INSERT, 0, 0, 256, -256, -256, 768, 256, 256));
        // inverted box, stored as given
        send_command(box_cmd(atpf_pkg::OP_INSERT, 0, 0, 512, 512, 512,
                             -512, -512, -512));
        send_command(box_cmd(atpf_pkg::OP_INSERT, 0, 0, COORD_MIN, COORD_MIN, COORD_MIN,
                             COORD_MAX, COORD_MAX, COORD_MAX));
        // one LSB clear of slot 0 on x
        send_command(box_cmd(atpf_pkg::OP_INSERT, 0, 0, 257, -256, -256, 300, 256, 256));
        send_command(box_cmd(atpf_pkg::OP_TEST, 0, 2, 0, 0, 0, 0, 0, 0));
        send_command(box_cmd(atpf_pkg::OP_TEST, 5, 0, 0, 0, 0, 0, 0, 0));
        send_command(box_cmd(atpf_pkg::OP_TEST, 3, 3, 0, 0, 0, 0, 0, 0));
        send_command(box_cmd(atpf_pkg::OP_TEST, 1, 1, 0, 0, 0, 0, 0, 0));
        send_command(box_cmd(atpf_pkg::OP_FIND, 0, 0, 0, 0, 0, 0, 0, 0));
        send_command(box_cmd(atpf_pkg::OP_UPDATE, 0, 0, -128, -128, -128,
                             128, 128, 128));
        send_command(box_cmd(atpf_pkg::OP_UPDATE, 0, 0, -512, -512, -512,
                             512, 512, 512));
        // widening past the coordinate range saturates
        send_command(box_cmd(atpf_pkg::OP_UPDATE, 5, 0,
                             COORD_MIN + 10, COORD_MIN + 10, COORD_MIN + 10,
                             COORD_MAX - 10, COORD_MAX - 10, COORD_MAX - 10));
        send_command(box_cmd(atpf_pkg::OP_REMOVE, 1, 0, 0, 0, 0, 0, 0, 0));
        send_command(box_cmd(atpf_pkg::OP_REMOVE, 2, 0, 0, 0, 0, 0, 0, 0));
        // freed slots come back last-in first-out
        send_command(box_cmd(atpf_pkg::OP_INSERT, 0, 0, -100, -100, -100, 100, 100, 100));
        send_command(box_cmd(atpf_pkg::OP_INSERT, 0, 0, 1000, 1000, 1000,
                             2000, 2000, 2000));
        send_command(box_cmd(OP_SPARE_5, 31, 31, 0, 0, 0, 0, 0, 0));
        send_command(box_cmd(OP_SPARE_6, 31, 31, 0, 0, 0, 0, 0, 0));
        send_command(box_cmd(OP_SPARE_7, 31, 31, 0, 0, 0, 0, 0, 0));
        send_command(box_cmd(atpf_pkg::OP_FIND, 31, 0, 0, 0, 0, 0, 0, 0));
        send_command(box_cmd(atpf_pkg::OP_TEST, 0, 31, 0, 0, 0, 0, 0, 0));
        send_command(box_cmd(atpf_pkg::OP_UPDATE, 20, 0, 0, 0, 0, 0, 0, 0));
        send_command(box_cmd(atpf_pkg::OP_FIND, 3, 0, 0, 0, 0, 0, 0, 0));

        for (phase = 0; phase < PHASES; phase++)
        begin
            write_margin(margins[phase]);
            idle_pct = (phase == PHASES - 1) ? 0 : ((phase % 2) ? 40 : 15);
            counted = 0;
            while (counted < ITEMS_PER_PHASE)
            begin
                c = random_command(phase % 3);
                send_command(c);
                if (c.op <= atpf_pkg::OP_FIND)
                    counted++;
                if ($urandom_range(0, 99) < idle_pct)
                    idle_burst();
            end
        end

        start <= 1'b0;
        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES)
            @(posedge clk);
        if (sb.errors == 0 && sb.awaited.size() == 0)
            $display("** aabb_table_pair_finder: PASSED **");
        else
            $display("** aabb_table_pair_finder: FAILED **");
        $finish;
    end

endmodule
